@@ hw/rtl/adq_pkg.sv @@
// shared types and constants for the array deque
`timescale 1ns / 1ps
package adq_pkg;

  // operation codes carried by the mode field
  typedef enum logic [1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_POP_FRONT  = 2'd1,
    MODE_PUSH_REAR  = 2'd2,
    MODE_POP_REAR   = 2'd3
  } mode_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_REFUSED   = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CAP_W     = 8;
  localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned OUT_DEPTH = 4;

  // config register select (paddr bit above the byte offset)
  localparam logic CFG_REG_CAPACITY = 1'b0;

  // work handed from the front to the back, slot address travels beside it
  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [WORD_W-1:0] data;
    status_t           status;
    logic              now_empty;
  } cmd_info_t;

  // one finished transaction waiting on the result side
  typedef struct packed {
    logic [WORD_W-1:0] value;
    status_t           status;
    logic              now_empty;
  } res_t;

endpackage

@@ hw/rtl/array_double_ended_queue_core.sv @@
// top level of the array deque: config port, front, command queue, back
`timescale 1ns / 1ps
// Linear double-ended queue of signed 32-bit words over DEPTH slots, of which
// the capacity register selects how many are in use (0 acts as 1, values above
// DEPTH act as DEPTH). Each transaction is one push or pop at the front or the
// rear and yields exactly one result with the popped word, a status and the
// empty flag. The front part accepts one transaction per cycle while its
// two-entry command queue has room; the back part makes one access per cycle
// to the single-port slot memory, so the sustained rate is one transaction per
// clock when pop keeps up. A result passes the command queue, the registered
// slot read and the result queue before it is visible; a four-entry result queue
// lets input continue while results wait. Slots need no clearing after reset.
module array_double_ended_queue_core #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                push,
  output logic                full,
  input  logic [1:0]          in_mode,
  input  logic signed [31:0]  in_value_in,
  // result channel
  output logic                empty,
  input  logic                pop,
  output logic signed [31:0]  out_value_out,
  output logic [1:0]          out_status,
  output logic                out_now_empty,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import adq_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CQ_W = $bits(cmd_info_t) + IW;
  localparam int unsigned CQ_CW = $clog2(CMD_DEPTH + 1);

  logic [CAP_W-1:0] capacity_r;
  logic             cfg_wr;
  logic             accept;
  cmd_info_t        f_info;
  logic [IW-1:0]    f_addr;
  logic [CQ_W-1:0]  cq_out;
  logic             cq_empty;
  logic [CQ_CW-1:0] cq_count;
  cmd_info_t        b_info;
  logic [IW-1:0]    b_addr;
  logic             b_take;
  res_t             res;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == CFG_REG_CAPACITY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_wr) begin
      capacity_r <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == CFG_REG_CAPACITY) ? 32'(capacity_r) : '0;

  // front part
  assign accept = push && !full;

  adq_front #(
    .DEPTH(DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .mode    (in_mode),
    .value_in(in_value_in),
    .capacity(capacity_r),
    .cmd_info(f_info),
    .cmd_addr(f_addr)
  );

  // command queue between front and back
  adq_fifo #(
    .WIDTH(CQ_W),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (accept),
    .wr_data({f_addr, f_info}),
    .rd_en  (b_take),
    .rd_data(cq_out),
    .empty  (cq_empty),
    .full   (full),
    .count  (cq_count)
  );

  assign b_info = cmd_info_t'(cq_out[$bits(cmd_info_t)-1:0]);
  assign b_addr = cq_out[CQ_W-1 -: IW];

  // back part
  adq_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(!cq_empty),
    .cmd_info (b_info),
    .cmd_addr (b_addr),
    .cmd_take (b_take),
    .res_pop  (pop),
    .res      (res),
    .res_empty(empty)
  );

  assign out_value_out = res.value;
  assign out_status    = res.status;
  assign out_now_empty = res.now_empty;

  logic unused_cq_count;
  assign unused_cq_count = ^cq_count;

endmodule

@@ hw/rtl/adq_ram.sv @@
// generic single-port ram with registered read data
`timescale 1ns / 1ps
module adq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one access per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ hw/rtl/adq_fifo.sv @@
// small register queue used between stages
`timescale 1ns / 1ps
module adq_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       rd_en,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CW'(DEPTH));
  assign count   = cnt_r;
  assign rd_data = entry_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ hw/rtl/adq_front.sv @@
// front part: holds the indices, decides each operation and its status
`timescale 1ns / 1ps
module adq_front #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [1:0]                 mode,
  input  logic [adq_pkg::WORD_W-1:0] value_in,
  input  logic [adq_pkg::CAP_W-1:0]  capacity,
  output adq_pkg::cmd_info_t         cmd_info,
  output logic [$clog2(DEPTH)-1:0]   cmd_addr
);
  import adq_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned UW = ((IW > CAP_W) ? IW : CAP_W) + 1;

  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic          empty_r, empty_nxt;
  logic [UW-1:0] cap_ext, usable_cap, tail_plus;
  logic          rear_room;

  // capacity clamped to 1..DEPTH
  always_comb begin
    cap_ext = UW'(capacity);
    if (cap_ext == '0) begin
      usable_cap = UW'(1);
    end else if (cap_ext > UW'(DEPTH)) begin
      usable_cap = UW'(DEPTH);
    end else begin
      usable_cap = cap_ext;
    end
    tail_plus = UW'(tail_r) + UW'(1);
    rear_room = (tail_plus < usable_cap);
  end

  // classify the operation and update indices
  always_comb begin
    head_nxt           = head_r;
    tail_nxt           = tail_r;
    empty_nxt          = empty_r;
    cmd_addr           = '0;
    cmd_info.rd        = 1'b0;
    cmd_info.wr        = 1'b0;
    cmd_info.data      = value_in;
    cmd_info.status    = ST_OK;
    unique case (mode_t'(mode))
      MODE_PUSH_FRONT: begin
        if (empty_r) begin
          head_nxt    = '0;
          tail_nxt    = '0;
          empty_nxt   = 1'b0;
          cmd_info.wr = 1'b1;
        end else if (head_r == '0) begin
          cmd_info.status = ST_REFUSED;
        end else begin
          head_nxt    = head_r - 1'b1;
          cmd_addr    = head_r - 1'b1;
          cmd_info.wr = 1'b1;
        end
      end
      MODE_PUSH_REAR: begin
        if (empty_r) begin
          head_nxt    = '0;
          tail_nxt    = '0;
          empty_nxt   = 1'b0;
          cmd_info.wr = 1'b1;
        end else if (rear_room) begin
          tail_nxt    = tail_r + 1'b1;
          cmd_addr    = tail_r + 1'b1;
          cmd_info.wr = 1'b1;
        end else begin
          cmd_info.status = ST_REFUSED;
        end
      end
      MODE_POP_FRONT: begin
        if (empty_r) begin
          cmd_info.status = ST_UNDERFLOW;
        end else begin
          cmd_addr    = head_r;
          cmd_info.rd = 1'b1;
          if (head_r == tail_r) begin
            head_nxt  = '0;
            tail_nxt  = '0;
            empty_nxt = 1'b1;
          end else begin
            head_nxt = head_r + 1'b1;
          end
        end
      end
      MODE_POP_REAR: begin
        if (empty_r) begin
          cmd_info.status = ST_UNDERFLOW;
        end else begin
          cmd_addr    = tail_r;
          cmd_info.rd = 1'b1;
          if (head_r == tail_r) begin
            head_nxt  = '0;
            tail_nxt  = '0;
            empty_nxt = 1'b1;
          end else begin
            tail_nxt = tail_r - 1'b1;
          end
        end
      end
      default: begin
        cmd_info.status = ST_OK;
      end
    endcase
    cmd_info.now_empty = empty_nxt;
  end

  // index state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      empty_r <= 1'b1;
    end else if (accept) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      empty_r <= empty_nxt;
    end
  end

endmodule

@@ hw/rtl/adq_back.sv @@
// back part: runs slot reads and writes and queues the results
`timescale 1ns / 1ps
module adq_back #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cmd_valid,
  input  adq_pkg::cmd_info_t         cmd_info,
  input  logic [$clog2(DEPTH)-1:0]   cmd_addr,
  output logic                       cmd_take,
  input  logic                       res_pop,
  output adq_pkg::res_t              res,
  output logic                       res_empty
);
  import adq_pkg::*;

  localparam int unsigned OCW = $clog2(OUT_DEPTH + 1);

  logic              s1_valid_r;
  logic              s1_rd_r;
  status_t           s1_status_r;
  logic              s1_now_empty_r;
  logic [WORD_W-1:0] ram_rdata;
  logic [OCW-1:0]    out_cnt;
  logic [OCW:0]      reserved;
  res_t              res_in;
  logic              out_full;

  // issue only when the result queue has a place for it
  assign reserved = (OCW + 1)'(out_cnt) + (OCW + 1)'(s1_valid_r);
  assign cmd_take = cmd_valid && (reserved < (OCW + 1)'(OUT_DEPTH));

  adq_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_slots (
    .clk  (clk),
    .we   (cmd_take && cmd_info.wr),
    .addr (cmd_addr),
    .wdata(cmd_info.data),
    .rdata(ram_rdata)
  );

  // control for the access in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= cmd_take;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      s1_rd_r        <= cmd_info.rd;
      s1_status_r    <= cmd_info.status;
      s1_now_empty_r <= cmd_info.now_empty;
    end
  end

  // assemble the result transaction
  always_comb begin
    res_in.value     = s1_rd_r ? ram_rdata : '0;
    res_in.status    = s1_status_r;
    res_in.now_empty = s1_now_empty_r;
  end

  adq_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(OUT_DEPTH)
  ) u_res_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (s1_valid_r),
    .wr_data(res_in),
    .rd_en  (res_pop),
    .rd_data(res),
    .empty  (res_empty),
    .full   (out_full),
    .count  (out_cnt)
  );

  logic unused_full;
  assign unused_full = out_full;

endmodule

@@ bench/tb_array_double_ended_queue_core.sv @@
// self-checking bench for the array deque: directed table, then random phases over capacities
`timescale 1ns / 1ps
module tb_array_double_ended_queue_core;
  import adq_pkg::*;

  localparam int unsigned DEPTH = 128;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned PRESSURE_AT = 500;
  localparam int unsigned PRESSURE_LEN = 80;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned REPORT_MAX = 10;
  localparam logic [2:0] CAP_ADDR = {CFG_REG_CAPACITY, 2'b00};
  localparam int CAP_RANDOM = 999;
  localparam int NUM_PHASES = 13;

  // one directed operation, with the result written out where it is obvious
  typedef struct packed {
    mode_t op;
    logic [31:0] word;
    logic known;
    res_t want;
  } table_row_t;

  localparam table_row_t DIRECTED_ROWS [23] = '{
    // pops right after reset underflow
    '{MODE_POP_FRONT, 32'hFFFF_FFFF, 1'b1, '{32'h0, ST_UNDERFLOW, 1'b1}},
    '{MODE_POP_REAR, 32'hFFFF_FFFF, 1'b1, '{32'h0, ST_UNDERFLOW, 1'b1}},
    // push front on empty lands in slot 0, a second one is refused at head 0
    '{MODE_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1, '{32'h0, ST_OK, 1'b0}},
    '{MODE_PUSH_FRONT, 32'h0000_0001, 1'b1, '{32'h0, ST_REFUSED, 1'b0}},
    '{MODE_PUSH_REAR, 32'h8000_0000, 1'b1, '{32'h0, ST_OK, 1'b0}},
    '{MODE_PUSH_REAR, 32'hFFFF_FFFF, 1'b1, '{32'h0, ST_OK, 1'b0}},
    '{MODE_PUSH_REAR, 32'h0000_0000, 1'b1, '{32'h0, ST_OK, 1'b0}},
    '{MODE_POP_FRONT, 32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, ST_OK, 1'b0}},
    '{MODE_POP_REAR, 32'h8000_0000, 1'b1, '{32'h0000_0000, ST_OK, 1'b0}},
    '{MODE_POP_FRONT, 32'h7FFF_FFFF, 1'b1, '{32'h8000_0000, ST_OK, 1'b0}},
    // head at 2 now, two front pushes bring it down to slot 0
    '{MODE_PUSH_FRONT, 32'hA5A5_A5A5, 1'b0, '{32'h0, ST_OK, 1'b0}},
    '{MODE_PUSH_FRONT, 32'h5A5A_5A5A, 1'b0, '{32'h0, ST_OK, 1'b0}},
    '{MODE_POP_REAR, 32'h0000_0000, 1'b0, '{32'h0, ST_OK, 1'b0}},
    '{MODE_POP_REAR, 32'h0000_0000, 1'b0, '{32'h0, ST_OK, 1'b0}},
    // last word leaves from the front, queue empty again
    '{MODE_POP_FRONT, 32'h0000_0000, 1'b1, '{32'h5A5A_5A5A, ST_OK, 1'b1}},
    // push rear on empty, drain it from the front
    '{MODE_PUSH_REAR, 32'h0000_0001, 1'b1, '{32'h0, ST_OK, 1'b0}},
    '{MODE_POP_FRONT, 32'h0000_0000, 1'b0, '{32'h0, ST_OK, 1'b0}},
    '{MODE_PUSH_REAR, 32'hDEAD_BEEF, 1'b0, '{32'h0, ST_OK, 1'b0}},
    '{MODE_PUSH_REAR, 32'h0123_4567, 1'b0, '{32'h0, ST_OK, 1'b0}},
    '{MODE_POP_FRONT, 32'h0000_0000, 1'b0, '{32'h0, ST_OK, 1'b0}},
    '{MODE_PUSH_FRONT, 32'hFEDC_BA98, 1'b0, '{32'h0, ST_OK, 1'b0}},
    '{MODE_POP_REAR, 32'h0000_0000, 1'b0, '{32'h0, ST_OK, 1'b0}},
    '{MODE_POP_REAR, 32'h0000_0000, 1'b0, '{32'h0, ST_OK, 1'b0}}
  };

  // random phases: capacity, item count, percentage of pushes
  localparam int PHASE_CAP [NUM_PHASES] =
    '{0, 1, 2, 255, 128, 6, 3, 128, 64, 17, CAP_RANDOM, CAP_RANDOM, 128};
  localparam int PHASE_LEN [NUM_PHASES] =
    '{60, 60, 80, 220, 100, 100, 60, 200, 120, 90, 100, 100, 140};
  localparam int PHASE_PUSH_PCT [NUM_PHASES] =
    '{50, 50, 60, 90, 40, 60, 55, 85, 50, 55, 50, 50, 50};

  logic clk;
  logic rst_n;
  logic push;
  logic full;
  logic [1:0] in_mode;
  logic signed [31:0] in_value_in;
  logic empty;
  logic pop;
  logic signed [31:0] out_value_out;
  logic [1:0] out_status;
  logic out_now_empty;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  // shadow of the deque contents and its capacity register
  logic [31:0] slot_shadow [DEPTH];
  int unsigned head_idx;
  int unsigned tail_idx;
  bit dq_empty;
  logic [7:0] cap_shadow;

  res_t pending_deque_results [$];
  logic row_known;
  res_t row_want;
  bit idle_on;
  int unsigned accepted_count;
  int unsigned checked_count;
  int unsigned refused_count;
  int unsigned underflow_count;
  int unsigned pop_ok_count;
  int unsigned stall_cycles;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned hold_left;
  bit pressure_done;

  array_double_ended_queue_core #(.DEPTH(DEPTH)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_mode(in_mode),
    .in_value_in(in_value_in),
    .empty(empty),
    .pop(pop),
    .out_value_out(out_value_out),
    .out_status(out_status),
    .out_now_empty(out_now_empty),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("run limit of %0d cycles reached, %0d results still pending",
               LIMIT_CYCLES, pending_deque_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // apply one operation to the shadow deque and return what the block must answer
  function automatic res_t deque_op_result(mode_t op, logic [31:0] word);
    res_t r;
    int unsigned usable;
    r = '{32'h0, ST_OK, 1'b0};
    usable = (cap_shadow == 8'd0) ? 1 : ((cap_shadow > DEPTH) ? DEPTH : cap_shadow);
    case (op)
      MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
        if (dq_empty) begin
          head_idx = 0;
          tail_idx = 0;
          dq_empty = 1'b0;
          slot_shadow[0] = word;
        end else if (op == MODE_PUSH_FRONT) begin
          if (head_idx == 0) begin
            r.status = ST_REFUSED;
          end else begin
            head_idx--;
            slot_shadow[head_idx] = word;
          end
        end else if (tail_idx + 1 < usable) begin
          tail_idx++;
          slot_shadow[tail_idx] = word;
        end else begin
          r.status = ST_REFUSED;
        end
      end
      default: begin
        if (dq_empty) begin
          r.status = ST_UNDERFLOW;
        end else begin
          r.value = (op == MODE_POP_FRONT) ? slot_shadow[head_idx] : slot_shadow[tail_idx];
          if (head_idx == tail_idx) begin
            head_idx = 0;
            tail_idx = 0;
            dq_empty = 1'b1;
          end else if (op == MODE_POP_FRONT) begin
            head_idx++;
          end else begin
            tail_idx--;
          end
        end
      end
    endcase
    r.now_empty = dq_empty;
    return r;
  endfunction

  // monitor: record accepted transactions, check results against the oldest pending one
  always @(posedge clk) begin : monitor
    res_t calc;
    res_t got;
    res_t want;
    if (rst_n) begin
      if (push && full) stall_cycles++;
      if (push && !full) begin
        calc = deque_op_result(mode_t'(in_mode), in_value_in);
        pending_deque_results.push_back(row_known ? row_want : calc);
        accepted_count++;
        if (calc.status == ST_REFUSED) refused_count++;
        if (calc.status == ST_UNDERFLOW) underflow_count++;
        if (calc.status == ST_OK && (in_mode == MODE_POP_FRONT || in_mode == MODE_POP_REAR))
          pop_ok_count++;
      end
      if (pop && !empty) begin
        got = '{out_value_out, status_t'(out_status), out_now_empty};
        if (pending_deque_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("cycle %0d: result %h/%0d/%b arrived with nothing pending",
                     cycle_count, got.value, got.status, got.now_empty);
        end else begin
          want = pending_deque_results.pop_front();
          checked_count++;
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
              $display("cycle %0d: got value %h status %0d empty %b, wanted %h %0d %b",
                       cycle_count, got.value, got.status, got.now_empty,
                       want.value, want.status, want.now_empty);
          end
        end
      end
    end
  end

  // result side: random pop gaps plus one long hold-off to back the block up
  initial begin
    pop = 1'b0;
    hold_left = 0;
    pressure_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!pressure_done && accepted_count >= PRESSURE_AT) begin
        hold_left = PRESSURE_LEN;
        pressure_done = 1'b1;
      end else if (hold_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(1, 13);
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // offer one transaction, starting and ending just after a falling edge
  task automatic send_item(mode_t op, logic [31:0] word, logic known, res_t want);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    push <= 1'b1;
    in_mode <= op;
    in_value_in <= word;
    row_known = known;
    row_want = want;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  // write the capacity register once the block has drained, then read it back
  task automatic set_capacity(logic [7:0] cap);
    logic [31:0] rd;
    push <= 1'b0;
    while (pending_deque_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CAP_ADDR;
    pwdata <= {24'($urandom), cap};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cap_shadow = cap;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    if (rd[CAP_W-1:0] !== cap) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
        $display("capacity read back %h, wanted %h", rd[CAP_W-1:0], cap);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // stimulus
  initial begin : stimulus
    int cap_pick;
    mode_t op;
    rst_n = 1'b0;
    push = 1'b0;
    in_mode = MODE_PUSH_FRONT;
    in_value_in = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    row_known = 1'b0;
    row_want = '0;
    idle_on = 1'b1;
    head_idx = 0;
    tail_idx = 0;
    dq_empty = 1'b1;
    cap_shadow = CAP_RESET;
    foreach (slot_shadow[i]) slot_shadow[i] = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    foreach (DIRECTED_ROWS[i])
      send_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].word,
                DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].want);

    // random phases, contents carried across capacity changes
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      cap_pick = (PHASE_CAP[ph] == CAP_RANDOM) ? $urandom_range(0, 255) : PHASE_CAP[ph];
      if (ph == NUM_PHASES - 1) idle_on = 1'b0;
      set_capacity(cap_pick[7:0]);
      for (int k = 0; k < PHASE_LEN[ph]; k++) begin
        if ($urandom_range(1, 100) <= PHASE_PUSH_PCT[ph])
          op = ($urandom_range(1, 100) <= 65) ? MODE_PUSH_REAR : MODE_PUSH_FRONT;
        else
          op = ($urandom_range(0, 1) == 1) ? MODE_POP_FRONT : MODE_POP_REAR;
        send_item(op, $urandom, 1'b0, '0);
      end
    end

    // drain and settle
    push <= 1'b0;
    while (pending_deque_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("%0d transactions checked over %0d capacity settings, input stalled %0d cycles",
             checked_count, NUM_PHASES, stall_cycles);
    $display("%0d good pops, %0d refused pushes, %0d underflows, %0d mismatches",
             pop_ok_count, refused_count, underflow_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
